### rtl/segment_sphere_chord_length_core_macros.svh
// ----------------------------------------------------------------------------
// segment sphere chord length assertion macros
// implication checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SPHERE_CHORD_LENGTH_CORE_MACROS_SVH
`define SEGMENT_SPHERE_CHORD_LENGTH_CORE_MACROS_SVH

// same cycle implication
`define SSCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sscl check failed");

// next cycle implication
`define SSCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sscl check failed");

`endif

### rtl/sscl_pkg.sv
// ----------------------------------------------------------------------------
// sscl_pkg
// beat types, outcome codes and stage counts of the chord length pipeline
// ----------------------------------------------------------------------------
package sscl_pkg;

  localparam int unsigned PreStages  = 9;
  localparam int unsigned DivSteps   = 64;
  localparam int unsigned SqrtSteps  = 32;
  localparam int unsigned PipeStages = PreStages + DivSteps + SqrtSteps;

  typedef enum logic [2:0] {
    OC_TWO_HITS    = 3'd0,
    OC_OFF_SEGMENT = 3'd1,
    OC_TOO_FAR     = 3'd2,
    OC_TANGENT     = 3'd3,
    OC_DEGENERATE  = 3'd4
  } outcome_e;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] radius;
  } in_t;

  typedef struct packed {
    logic [31:0] chord_length;
    logic [2:0]  outcome;
  } out_t;

endpackage

### rtl/segment_sphere_chord_length_core.sv
// ----------------------------------------------------------------------------
// segment_sphere_chord_length_core
// chord length that a sphere cuts from a line segment, signed Q16.16 in,
// unsigned Q16.16 out, fully pipelined
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      in_valid_i / in_ready_o  in_i  (in_t)
//  out       output     out_valid_o / out_ready_i out_o (out_t)
//
//  one beat per cycle unless a waiting output stalls the pipeline
//  9 setup stages (diffs, 33x33 products, sums, split squares),
//  64 restoring division stages and 32 square root stages, one bit each
//  reset clears the valid bits only, no state is kept between beats
//  a waiting output stalls the whole pipeline only once the last stage holds
//  a beat, empty stages keep filling meanwhile
// ----------------------------------------------------------------------------
module segment_sphere_chord_length_core
  import sscl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic                  en;
  logic                  out_free;
  logic [PipeStages-1:0] vld_q, vld_d;
  logic                  out_valid_q;
  out_t                  out_q, out_d;

  assign out_free   = ~out_valid_q | out_ready_i;
  assign en         = out_free | ~vld_q[PipeStages-1];
  assign in_ready_o = en;
  assign vld_d      = {vld_q[PipeStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= vld_d;
      end
      if (out_free) begin
        out_valid_q <= vld_q[PipeStages-1];
      end
    end
  end

  // stage 1: differences
  logic signed [32:0] s1_d_d [3], s1_d_q [3];
  logic signed [32:0] s1_w_d [3], s1_w_q [3];
  logic        [30:0] s1_r_q;

  always_comb begin
    s1_d_d[0] = {in_i.end_x[31], in_i.end_x} - {in_i.start_x[31], in_i.start_x};
    s1_d_d[1] = {in_i.end_y[31], in_i.end_y} - {in_i.start_y[31], in_i.start_y};
    s1_d_d[2] = {in_i.end_z[31], in_i.end_z} - {in_i.start_z[31], in_i.start_z};
    s1_w_d[0] = {in_i.center_x[31], in_i.center_x} - {in_i.start_x[31], in_i.start_x};
    s1_w_d[1] = {in_i.center_y[31], in_i.center_y} - {in_i.start_y[31], in_i.start_y};
    s1_w_d[2] = {in_i.center_z[31], in_i.center_z} - {in_i.start_z[31], in_i.start_z};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_d_q <= s1_d_d;
      s1_w_q <= s1_w_d;
      s1_r_q <= in_i.radius;
    end
  end

  // stage 2: products
  logic signed [65:0] s2_dd_d [3], s2_dd_q [3];
  logic signed [65:0] s2_wd_d [3], s2_wd_q [3];
  logic signed [65:0] s2_xa_d [3], s2_xa_q [3];
  logic signed [65:0] s2_xb_d [3], s2_xb_q [3];
  logic        [61:0] s2_rr_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_dd_d[k] = 66'(s1_d_q[k]) * 66'(s1_d_q[k]);
      s2_wd_d[k] = 66'(s1_w_q[k]) * 66'(s1_d_q[k]);
    end
    s2_xa_d[0] = 66'(s1_w_q[1]) * 66'(s1_d_q[2]);
    s2_xb_d[0] = 66'(s1_w_q[2]) * 66'(s1_d_q[1]);
    s2_xa_d[1] = 66'(s1_w_q[2]) * 66'(s1_d_q[0]);
    s2_xb_d[1] = 66'(s1_w_q[0]) * 66'(s1_d_q[2]);
    s2_xa_d[2] = 66'(s1_w_q[0]) * 66'(s1_d_q[1]);
    s2_xb_d[2] = 66'(s1_w_q[1]) * 66'(s1_d_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_dd_q <= s2_dd_d;
      s2_wd_q <= s2_wd_d;
      s2_xa_q <= s2_xa_d;
      s2_xb_q <= s2_xb_d;
      s2_rr_q <= 62'(s1_r_q) * 62'(s1_r_q);
    end
  end

  // stage 3: a, dot and cross product
  logic        [65:0] s3_a_q;
  logic signed [66:0] s3_dot_q;
  logic signed [65:0] s3_x_q [3];
  logic        [61:0] s3_rr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_a_q   <= $unsigned(s2_dd_q[0]) + $unsigned(s2_dd_q[1]) + $unsigned(s2_dd_q[2]);
      s3_dot_q <= 67'(s2_wd_q[0]) + 67'(s2_wd_q[1]) + 67'(s2_wd_q[2]);
      for (int k = 0; k < 3; k++) begin
        s3_x_q[k] <= s2_xa_q[k] - s2_xb_q[k];
      end
      s3_rr_q <= s2_rr_q;
    end
  end

  // stage 4: early outcome, magnitudes
  outcome_e    s4_oc_d, s4_oc_q;
  logic [64:0] s4_ax_d [3], s4_ax_q [3];
  logic [65:0] s4_a_q;
  logic [61:0] s4_rr_q;

  always_comb begin
    if (s3_a_q == '0) begin
      s4_oc_d = OC_DEGENERATE;
    end else if (s3_dot_q[66] || ($signed({1'b0, s3_a_q}) < s3_dot_q)) begin
      s4_oc_d = OC_OFF_SEGMENT;
    end else begin
      s4_oc_d = OC_TWO_HITS;
    end
    for (int k = 0; k < 3; k++) begin
      s4_ax_d[k] = s3_x_q[k][65] ? 65'(-s3_x_q[k]) : 65'(s3_x_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_oc_q <= s4_oc_d;
      s4_ax_q <= s4_ax_d;
      s4_a_q  <= s3_a_q;
      s4_rr_q <= s3_rr_q;
    end
  end

  // stage 5: partial products of the squares and of a*r*r
  logic [65:0] s5_hh_q [3];
  logic [64:0] s5_hl_q [3];
  logic [63:0] s5_ll_q [3];
  logic [63:0] s5_ahrh_q;
  logic [65:0] s5_ahrl_q;
  logic [61:0] s5_alrh_q;
  logic [63:0] s5_alrl_q;
  logic [65:0] s5_a_q;
  outcome_e    s5_oc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s5_hh_q[k] <= 66'(s4_ax_q[k][64:32]) * 66'(s4_ax_q[k][64:32]);
        s5_hl_q[k] <= 65'(s4_ax_q[k][64:32]) * 65'(s4_ax_q[k][31:0]);
        s5_ll_q[k] <= 64'(s4_ax_q[k][31:0]) * 64'(s4_ax_q[k][31:0]);
      end
      s5_ahrh_q <= 64'(s4_a_q[65:32]) * 64'(s4_rr_q[61:32]);
      s5_ahrl_q <= 66'(s4_a_q[65:32]) * 66'(s4_rr_q[31:0]);
      s5_alrh_q <= 62'(s4_a_q[31:0]) * 62'(s4_rr_q[61:32]);
      s5_alrl_q <= 64'(s4_a_q[31:0]) * 64'(s4_rr_q[31:0]);
      s5_a_q    <= s4_a_q;
      s5_oc_q   <= s4_oc_q;
    end
  end

  // stage 6: squares and a*r*r
  logic [129:0] s6_xsq_q [3];
  logic [127:0] s6_arr_q;
  logic [65:0]  s6_a_q;
  outcome_e     s6_oc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s6_xsq_q[k] <= {s5_hh_q[k], 64'd0} + (130'(s5_hl_q[k]) << 33) + 130'(s5_ll_q[k]);
      end
      s6_arr_q <= {s5_ahrh_q, 64'd0} + (128'(s5_ahrl_q) << 32) + (128'(s5_alrh_q) << 32)
                + 128'(s5_alrl_q);
      s6_a_q   <= s5_a_q;
      s6_oc_q  <= s5_oc_q;
    end
  end

  // stage 7: squared cross product length
  logic [131:0] s7_cr_q;
  logic [127:0] s7_arr_q;
  logic [65:0]  s7_a_q;
  outcome_e     s7_oc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_cr_q  <= 132'(s6_xsq_q[0]) + 132'(s6_xsq_q[1]) + 132'(s6_xsq_q[2]);
      s7_arr_q <= s6_arr_q;
      s7_a_q   <= s6_a_q;
      s7_oc_q  <= s6_oc_q;
    end
  end

  // stage 8: q and final outcome
  logic [132:0] s8_q_d, s8_q_q;
  outcome_e     s8_oc_d, s8_oc_q;
  logic [65:0]  s8_a_q;

  always_comb begin
    s8_q_d  = {5'd0, s7_arr_q} - {1'b0, s7_cr_q};
    s8_oc_d = s7_oc_q;
    if (s7_oc_q == OC_TWO_HITS) begin
      if (s8_q_d[132]) begin
        s8_oc_d = OC_TOO_FAR;
      end else if (s8_q_d == '0) begin
        s8_oc_d = OC_TANGENT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q_q  <= s8_q_d;
      s8_oc_q <= s8_oc_d;
      s8_a_q  <= s7_a_q;
    end
  end

  // stage 9: saturation check and divider setup
  logic [65:0]  dv_p_q   [DivSteps+1];
  logic [63:0]  dv_l_q   [DivSteps+1];
  logic [65:0]  dv_a_q   [DivSteps];
  outcome_e     dv_oc_q  [DivSteps+1];
  logic         dv_sat_q [DivSteps+1];
  logic [129:0] s9_n;

  assign s9_n = {s8_q_q[127:0], 2'b00};

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_p_q[0]   <= s9_n[129:64];
      dv_l_q[0]   <= s9_n[63:0];
      dv_a_q[0]   <= s8_a_q;
      dv_oc_q[0]  <= s8_oc_q;
      dv_sat_q[0] <= (s9_n >= {s8_a_q, 64'd0});
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [66:0] t;
    logic        ge;
    assign t  = {dv_p_q[j], dv_l_q[j][63]};
    assign ge = (t >= {1'b0, dv_a_q[j]});

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_p_q[j+1]   <= ge ? 66'(t - {1'b0, dv_a_q[j]}) : t[65:0];
        dv_l_q[j+1]   <= {dv_l_q[j][62:0], ge};
        dv_oc_q[j+1]  <= dv_oc_q[j];
        dv_sat_q[j+1] <= dv_sat_q[j];
      end
    end

    if (j + 1 < DivSteps) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_a_q[j+1] <= dv_a_q[j];
        end
      end
    end
  end

  // integer square root, one root bit per stage
  logic [63:0] sq_x_q    [1:SqrtSteps];
  logic [33:0] sq_rem_q  [1:SqrtSteps];
  logic [31:0] sq_root_q [1:SqrtSteps];
  outcome_e    sq_oc_q   [1:SqrtSteps];
  logic        sq_sat_q  [1:SqrtSteps];

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    logic [63:0] src_x;
    logic [33:0] src_rem;
    logic [31:0] src_root;
    outcome_e    src_oc;
    logic        src_sat;
    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign src_x    = dv_l_q[DivSteps];
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_oc   = dv_oc_q[DivSteps];
      assign src_sat  = dv_sat_q[DivSteps];
    end else begin : g_rest
      assign src_x    = sq_x_q[i];
      assign src_rem  = sq_rem_q[i];
      assign src_root = sq_root_q[i];
      assign src_oc   = sq_oc_q[i];
      assign src_sat  = sq_sat_q[i];
    end

    assign cur   = {src_rem, src_x[63:62]};
    assign trial = {2'b00, src_root, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_root_q[i+1] <= {src_root[30:0], ge};
        sq_oc_q[i+1]   <= src_oc;
        sq_sat_q[i+1]  <= src_sat;
      end
    end

    if (i + 1 < SqrtSteps) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en) begin
          sq_x_q[i+1]   <= {src_x[61:0], 2'b00};
          sq_rem_q[i+1] <= ge ? 34'(cur - trial) : cur[33:0];
        end
      end
    end
  end

  // output register
  always_comb begin
    out_d.outcome = sq_oc_q[SqrtSteps];
    if (sq_oc_q[SqrtSteps] != OC_TWO_HITS) begin
      out_d.chord_length = '0;
    end else if (sq_sat_q[SqrtSteps]) begin
      out_d.chord_length = '1;
    end else begin
      out_d.chord_length = sq_root_q[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### rtl/sscl_checker.sv
// ----------------------------------------------------------------------------
// sscl_checker
// port level checks of the chord length core, bound to the top level
// ----------------------------------------------------------------------------
`include "segment_sphere_chord_length_core_macros.svh"

module sscl_checker
  import sscl_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  `SSCL_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o))
  `SSCL_ASSERT_IMP(a_chord_zero, out_valid_o && (out_o.outcome != OC_TWO_HITS), out_o.chord_length == '0)
  `SSCL_ASSERT_IMP(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i)
  `SSCL_ASSERT_IMP(a_drain_ready, out_valid_o && out_ready_i, in_ready_o)

endmodule

bind segment_sphere_chord_length_core sscl_checker u_sscl_checker (.*);
